[hdl/bsfr_pkg.sv]
// Shared types, constants and helpers for the blurred scope frame renderer.
// No dependencies; imported by bsfr_frame_engine and blur_scope_frame_renderer.

package bsfr_pkg;

	// Frame geometry: the store keeps a one-pixel border round the visible frame
	localparam int FRAME_WIDTH  = 256;
	localparam int FRAME_HEIGHT = 128;
	localparam int ROW_STRIDE   = FRAME_WIDTH + 2;
	localparam int STORE_SIZE   = ROW_STRIDE * (FRAME_HEIGHT + 2);
	localparam int ADDR_W       = $clog2(STORE_SIZE);

	// Blur walk: from just inside the top-left corner, one stride per visible row
	localparam int BLUR_FIRST = ROW_STRIDE + 1;
	localparam int BLUR_LAST  = ROW_STRIDE + ROW_STRIDE * FRAME_HEIGHT;
	localparam int DOWN_LIMIT = STORE_SIZE - ROW_STRIDE;

	// Trace geometry
	localparam int COL_W = $clog2(FRAME_WIDTH);
	localparam int ROW_W = $clog2(FRAME_HEIGHT);
	localparam int TRY_W = 18;

	// Sample store
	localparam int SMP_DEPTH = 128;
	localparam int SMP_W     = $clog2(SMP_DEPTH);

	// Request codes
	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_RENDER = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	// Register indexes
	localparam logic [1:0] CFG_DECAY = 2'd0;
	localparam logic [1:0] CFG_SHIFT = 2'd1;
	localparam logic [1:0] CFG_TRACE = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [6:0]         sample_index;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic [7:0]         pixel_x;
		logic [6:0]         pixel_y;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pixel_value;
		logic       is_read_result;
	} out_item_t;

	typedef struct packed {
		logic [7:0] decay_step;
		logic [3:0] sample_shift;
		logic [7:0] trace_value;
	} cfg_t;

	// Top level to engine
	typedef struct packed {
		logic start;
		logic take;
	} ctl_t;

	// Engine to top level
	typedef struct packed {
		logic idle;
		logic done;
	} sts_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_PIX,
		ST_BL_UP,
		ST_BL_RIGHT,
		ST_BL_DOWN,
		ST_BL_WRITE,
		ST_TR_RD,
		ST_TR_Y,
		ST_TR_SEG,
		ST_TR_DRAW,
		ST_DONE
	} phase_t;

	// Store address of (row, col), both already offset past the border
	function automatic logic [ADDR_W-1:0] frame_addr(input logic [ADDR_W-1:0] row,
		input logic [ADDR_W-1:0] col);
		frame_addr = ADDR_W'(row * ROW_STRIDE + col);
	endfunction

endpackage

[hdl/blur_scope_frame_renderer.sv]
// Top level of the blurred scope frame renderer: request and response
// channels, register port and output register. Depends on bsfr_pkg, bsfr_frame_engine.
//
//  channel   signals                         width  notes
//  request   req_valid, req_ready, req       56     in_item_t, one request at a time
//  response  rsp_valid, rsp_ready, rsp       9      out_item_t, one per request
//  config    cfg_write, cfg_index, cfg_data  2 + 8  write only, no wait
//
// A write or other short request goes from idle straight to done, and a pixel read
// adds one read state; a render blurs all 33024 positions, each read through the single
// read port of the frame store, then draws the trace column by column, one pixel at a
// time. After reset the frame store is cleared, one byte a cycle, all 33540 bytes,
// before the first request is taken. A waiting response holds the next request's
// result back but not its acceptance.

module blur_scope_frame_renderer import bsfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp,
	input  logic      cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cfg_t      cfg_q;
	ctl_t      ctl;
	sts_t      sts;
	out_item_t eng_result;
	out_item_t rsp_q;
	logic      rsp_valid_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay_step   <= 8'd2;
			cfg_q.sample_shift <= 4'd9;
			cfg_q.trace_value  <= 8'hFF;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_DECAY: cfg_q.decay_step   <= cfg_data;
				CFG_SHIFT: cfg_q.sample_shift <= cfg_data[3:0];
				CFG_TRACE: cfg_q.trace_value  <= cfg_data;
				default:   cfg_q <= cfg_q;
			endcase
		end
	end

	// Handshake with the engine
	assign req_ready = sts.idle;
	assign ctl.start = req_valid && req_ready;
	assign ctl.take  = sts.done && (!rsp_valid_q || rsp_ready);

	bsfr_frame_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.ctl    (ctl),
		.item   (req),
		.sts    (sts),
		.result (eng_result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) rsp_q <= eng_result;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[hdl/bsfr_frame_engine.sv]
// Frame engine: frame store, sample store and the sequencer that blurs,
// draws the trace and serves pixel reads. Depends on bsfr_pkg.

module bsfr_frame_engine import bsfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  ctl_t      ctl,
	input  in_item_t  item,
	output sts_t      sts,
	output out_item_t result
);

	phase_t state_q, state_d;

	// Frame store, one write and one registered read per cycle
	logic [7:0]        frame_mem [STORE_SIZE];
	logic              fwe;
	logic [ADDR_W-1:0] fwaddr, fraddr;
	logic [7:0]        fwdata, frd_q;

	// Sample store with per-entry valid bits (unwritten entries read as zero)
	logic [31:0]          smp_mem [SMP_DEPTH];
	logic [SMP_DEPTH-1:0] smp_vld_q;
	logic [SMP_W-1:0]     smp_raddr;
	logic [31:0]          smp_rd_q;
	logic                 smp_rvld_q;

	// Sequencer registers
	logic [ADDR_W-1:0] p_q;
	logic [9:0]        acc_q;
	logic [7:0]        left_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  y_q, prev_q, cur_q, hi_q;
	logic              inrange_q;
	out_item_t         res_q;

	// Blur arithmetic
	logic       down_ok;
	logic [9:0] blur_sum;
	logic [7:0] blur_avg, blur_val;

	// Trace arithmetic
	logic signed [15:0]      smp_l, smp_r, sh_l, sh_r;
	logic signed [TRY_W-1:0] half_r, y_sum;
	logic [ROW_W-1:0]        y_clamped, seg_lo, seg_hi, prev_eff;
	logic                    col_last;

	logic [ADDR_W-1:0] pix_addr, draw_addr;

	// Neighbour sums and decay
	assign down_ok  = p_q < ADDR_W'(DOWN_LIMIT);
	assign blur_sum = acc_q + (down_ok ? {2'b00, frd_q} : 10'd0);
	assign blur_avg = blur_sum[9:2];
	assign blur_val = (blur_avg > cfg.decay_step) ? blur_avg - cfg.decay_step : blur_avg;

	// Trace height from one sample pair; the halving truncates toward zero
	assign smp_l  = smp_rvld_q ? $signed(smp_rd_q[15:0]) : 16'sd0;
	assign smp_r  = smp_rvld_q ? $signed(smp_rd_q[31:16]) : 16'sd0;
	assign sh_l   = smp_l >>> cfg.sample_shift;
	assign sh_r   = smp_r >>> cfg.sample_shift;
	assign half_r = (TRY_W'(sh_r) + $signed({{(TRY_W-1){1'b0}}, sh_r[15]})) >>> 1;
	assign y_sum  = $signed(TRY_W'(FRAME_HEIGHT / 2)) + TRY_W'(sh_l) + half_r;

	always_comb begin
		if (y_sum < $signed(TRY_W'(0))) begin
			y_clamped = '0;
		end else if (y_sum > $signed(TRY_W'(FRAME_HEIGHT - 1))) begin
			y_clamped = ROW_W'(FRAME_HEIGHT - 1);
		end else begin
			y_clamped = y_sum[ROW_W-1:0];
		end
	end

	// Segment ends; the first column starts from its own height
	assign prev_eff = (col_q == '0) ? y_q : prev_q;
	assign seg_lo   = (prev_eff < y_q) ? prev_eff : y_q;
	assign seg_hi   = (prev_eff < y_q) ? y_q : prev_eff;
	assign col_last = col_q == COL_W'(FRAME_WIDTH - 1);

	assign smp_raddr = SMP_W'(col_q >> 1);
	assign pix_addr  = frame_addr(ADDR_W'(item.pixel_y) + ADDR_W'(1),
		ADDR_W'(item.pixel_x) + ADDR_W'(1));
	assign draw_addr = frame_addr(ADDR_W'(cur_q) + ADDR_W'(1), ADDR_W'(col_q) + ADDR_W'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (p_q == ADDR_W'(STORE_SIZE - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (ctl.start) begin
					case (item.req_type)
						REQ_RENDER: state_d = ST_BL_UP;
						REQ_READ:   state_d = ST_RD_PIX;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_RD_PIX:   state_d = ST_DONE;
			ST_BL_UP:    state_d = ST_BL_RIGHT;
			ST_BL_RIGHT: state_d = ST_BL_DOWN;
			ST_BL_DOWN:  state_d = ST_BL_WRITE;
			ST_BL_WRITE: begin
				state_d = (p_q == ADDR_W'(BLUR_LAST)) ? ST_TR_RD : ST_BL_RIGHT;
			end
			ST_TR_RD:  state_d = ST_TR_Y;
			ST_TR_Y:   state_d = ST_TR_SEG;
			ST_TR_SEG: state_d = ST_TR_DRAW;
			ST_TR_DRAW: begin
				if (cur_q == hi_q) state_d = col_last ? ST_DONE : ST_TR_RD;
			end
			ST_DONE: begin
				if (ctl.take) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Memory port control
	always_comb begin
		fwe    = 1'b0;
		fwaddr = p_q;
		fwdata = '0;
		fraddr = '0;
		case (state_q)
			ST_CLEAR: fwe = 1'b1;
			ST_IDLE:     fraddr = pix_addr;
			ST_BL_UP:    fraddr = p_q - ADDR_W'(ROW_STRIDE);
			ST_BL_RIGHT: fraddr = p_q + ADDR_W'(1);
			ST_BL_DOWN:  fraddr = down_ok ? p_q + ADDR_W'(ROW_STRIDE) : p_q;
			ST_BL_WRITE: begin
				fwe    = 1'b1;
				fwdata = blur_val;
				fraddr = p_q + ADDR_W'(1) - ADDR_W'(ROW_STRIDE);
			end
			ST_TR_DRAW: begin
				fwe    = 1'b1;
				fwaddr = draw_addr;
				fwdata = cfg.trace_value;
			end
			default: fraddr = '0;
		endcase
	end

	// Frame store
	always_ff @(posedge clk) begin
		if (fwe) frame_mem[fwaddr] <= fwdata;
		frd_q <= frame_mem[fraddr];
	end

	// Sample store
	always_ff @(posedge clk) begin
		if (ctl.start && item.req_type == REQ_WRITE) begin
			smp_mem[item.sample_index] <= {item.right_sample, item.left_sample};
		end
		smp_rd_q <= smp_mem[smp_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_vld_q  <= '0;
			smp_rvld_q <= 1'b0;
		end else begin
			if (ctl.start && item.req_type == REQ_WRITE) smp_vld_q[item.sample_index] <= 1'b1;
			smp_rvld_q <= smp_vld_q[smp_raddr];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			p_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: p_q <= p_q + ADDR_W'(1);
				ST_IDLE:  p_q <= ADDR_W'(BLUR_FIRST);
				ST_BL_WRITE: p_q <= p_q + ADDR_W'(1);
				default: p_q <= p_q;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				left_q    <= '0;
				col_q     <= '0;
				inrange_q <= (int'(item.pixel_x) < FRAME_WIDTH) && (int'(item.pixel_y) < FRAME_HEIGHT);
				res_q.pixel_value    <= '0;
				res_q.is_read_result <= item.req_type == REQ_READ;
			end
			ST_RD_PIX:   res_q.pixel_value <= inrange_q ? frd_q : 8'd0;
			ST_BL_RIGHT: acc_q <= {2'b00, left_q} + {2'b00, frd_q};
			ST_BL_DOWN:  acc_q <= acc_q + {2'b00, frd_q};
			ST_BL_WRITE: left_q <= blur_val;
			ST_TR_Y:     y_q <= y_clamped;
			ST_TR_SEG: begin
				cur_q  <= seg_lo;
				hi_q   <= seg_hi;
				prev_q <= y_q;
			end
			ST_TR_DRAW: begin
				if (cur_q == hi_q) col_q <= col_q + COL_W'(1);
				else cur_q <= cur_q + ROW_W'(1);
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign sts.idle = state_q == ST_IDLE;
	assign sts.done = state_q == ST_DONE;
	assign result   = res_q;

	// Frame writes come only from the clearing pass, the blur or the trace
	assert property (@(posedge clk) disable iff (!arst_n)
		fwe |-> (state_q == ST_CLEAR || state_q == ST_BL_WRITE || state_q == ST_TR_DRAW))
		else $error("frame write outside clear, blur or trace");

	// A new request is only started from idle
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> state_q == ST_IDLE)
		else $error("request started while busy");

	// The blur walk stays inside the store
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BL_WRITE |-> p_q <= ADDR_W'(BLUR_LAST) && p_q >= ADDR_W'(BLUR_FIRST))
		else $error("blur position out of range");

	// Segment drawing climbs from low end to high end
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TR_DRAW |-> cur_q <= hi_q)
		else $error("trace segment overran its end");

endmodule

[tb/blur_scope_frame_renderer_tb.sv]
// Self-checking bench for blur_scope_frame_renderer: directed then random requests,
// every response checked against a bench-side model of the frame and sample stores.
// Depends on bsfr_pkg and the renderer RTL.

module blur_scope_frame_renderer_tb;
	import bsfr_pkg::*;

	localparam int         SMP_MASK = SMP_DEPTH - 1;
	localparam logic [1:0] REQ_NONE = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	in_item_t   req_item = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	out_item_t  rsp_item;
	logic       cfg_write = 1'b0;
	logic [1:0] cfg_index = CFG_DECAY;
	logic [7:0] cfg_data = '0;
	logic       req_fire = 1'b0;

	in_item_t   req_q[$];
	out_item_t  pixel_rsp_q[$];
	int         send_gap_pct = 0;
	int         rsp_stall_pct = 0;
	int         n_fail = 0;

	// Bench copy of the block state
	logic [7:0]         frame_px [STORE_SIZE];
	logic signed [15:0] left_smp [SMP_DEPTH];
	logic signed [15:0] right_smp [SMP_DEPTH];
	cfg_t               regs_shadow;

	blur_scope_frame_renderer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Scope row for one sample pair, clamped into the frame
	function automatic int trace_row(input int pair);
		int l, r, y;
		l = int'(left_smp[pair & SMP_MASK]) >>> regs_shadow.sample_shift;
		r = int'(right_smp[pair & SMP_MASK]) >>> regs_shadow.sample_shift;
		y = FRAME_HEIGHT / 2 + l + r / 2;
		if (y < 0)
			y = 0;
		if (y >= FRAME_HEIGHT)
			y = FRAME_HEIGHT - 1;
		return y;
	endfunction

	// Apply one accepted request to the bench state and queue its response
	task automatic scope_model_step(input in_item_t r);
		out_item_t res;
		int sum, dn, prev_y, y, lo, hi;
		res = '0;
		case (r.req_type)
		REQ_WRITE: begin
			left_smp[r.sample_index] = r.left_sample;
			right_smp[r.sample_index] = r.right_sample;
		end
		REQ_RENDER: begin
			// in-place blur; up and left already hold new values, past-the-end reads as zero
			for (int p = BLUR_FIRST; p <= BLUR_LAST; p++) begin
				dn = (p + ROW_STRIDE < STORE_SIZE) ? int'(frame_px[p + ROW_STRIDE]) : 0;
				sum = (int'(frame_px[p - ROW_STRIDE]) + int'(frame_px[p - 1]) +
					int'(frame_px[p + 1]) + dn) >> 2;
				if (sum > int'(regs_shadow.decay_step))
					sum -= int'(regs_shadow.decay_step);
				frame_px[p] = sum[7:0];
			end
			// trace: vertical run from the previous row to this one, per column
			prev_y = trace_row(0);
			for (int x = 0; x < FRAME_WIDTH; x++) begin
				y = trace_row(x >> 1);
				lo = (prev_y < y) ? prev_y : y;
				hi = (prev_y < y) ? y : prev_y;
				for (int yy = lo; yy <= hi; yy++)
					frame_px[(yy + 1) * ROW_STRIDE + x + 1] = regs_shadow.trace_value;
				prev_y = y;
			end
		end
		REQ_READ: begin
			res.is_read_result = 1'b1;
			if (r.pixel_x < FRAME_WIDTH && r.pixel_y < FRAME_HEIGHT)
				res.pixel_value =
					frame_px[(int'(r.pixel_y) + 1) * ROW_STRIDE + int'(r.pixel_x) + 1];
		end
		default: ;
		endcase
		pixel_rsp_q.push_back(res);
	endtask

	// Request of the given type with every other field random
	function automatic in_item_t noise_item(input logic [1:0] kind);
		in_item_t it;
		it.req_type     = kind;
		it.sample_index = 7'($urandom);
		it.left_sample  = 16'($urandom);
		it.right_sample = 16'($urandom);
		it.pixel_x      = 8'($urandom);
		it.pixel_y      = 7'($urandom);
		return it;
	endfunction

	// Either full scale or at most 1 << (sample_shift + 6) in magnitude, capped at 32767
	function automatic logic signed [15:0] sample_value();
		int amp;
		if ($urandom_range(1) == 1)
			return 16'($urandom);
		amp = 1 << (int'(regs_shadow.sample_shift) + 6);
		if (amp > 32767)
			amp = 32767;
		return 16'(int'($urandom_range(2 * amp)) - amp);
	endfunction

	task automatic queue_write(input logic [6:0] idx, input logic signed [15:0] l,
		input logic signed [15:0] r);
		in_item_t it;
		it = noise_item(REQ_WRITE);
		it.sample_index = idx;
		it.left_sample  = l;
		it.right_sample = r;
		req_q.push_back(it);
	endtask

	task automatic queue_read(input logic [7:0] x, input logic [6:0] y);
		in_item_t it;
		it = noise_item(REQ_READ);
		it.pixel_x = x;
		it.pixel_y = y;
		req_q.push_back(it);
	endtask

	// Register writes back to back; only called with no request outstanding
	task automatic program_regs(input logic [7:0] decay, input logic [3:0] shift,
		input logic [7:0] trace);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_DECAY;
		cfg_data  <= decay;
		@(negedge clk);
		cfg_index <= CFG_SHIFT;
		cfg_data  <= {4'($urandom), shift};
		@(negedge clk);
		cfg_index <= CFG_TRACE;
		cfg_data  <= trace;
		@(negedge clk);
		cfg_write <= 1'b0;
		regs_shadow.decay_step   = decay;
		regs_shadow.sample_shift = shift;
		regs_shadow.trace_value  = trace;
	endtask

	task automatic wait_all_answered();
		while (req_q.size() != 0 || req_valid || pixel_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	// Request driver: new request only once the last one was taken
	always @(negedge clk) begin
		if (!req_valid || req_fire) begin
			if (req_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				req_item  <= req_q.pop_front();
				req_valid <= 1'b1;
			end else
				req_valid <= 1'b0;
		end
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// Handshake monitor: predict on request, compare on response
	always @(posedge clk) begin : watch_handshakes
		out_item_t want;
		req_fire <= req_valid && req_ready;
		if (arst_n && req_valid && req_ready)
			scope_model_step(req_item);
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pixel_rsp_q.size() == 0) begin
				$display("%0t: response with nothing expected: pixel_value %0d is_read_result %0d",
					$time, rsp_item.pixel_value, rsp_item.is_read_result);
				n_fail++;
			end else begin
				want = pixel_rsp_q.pop_front();
				if (rsp_item.pixel_value !== want.pixel_value) begin
					$display("%0t: pixel_value expected %0d got %0d",
						$time, want.pixel_value, rsp_item.pixel_value);
					n_fail++;
				end
				if (rsp_item.is_read_result !== want.is_read_result) begin
					$display("%0t: is_read_result expected %0d got %0d",
						$time, want.is_read_result, rsp_item.is_read_result);
					n_fail++;
				end
			end
		end
	end

	// Stimulus: one directed phase, then random phases under different settings
	initial begin
		int idx, roll, x, y0;
		foreach (frame_px[i])
			frame_px[i] = '0;
		foreach (left_smp[i]) begin
			left_smp[i]  = '0;
			right_smp[i] = '0;
		end
		regs_shadow.decay_step   = 8'd2;
		regs_shadow.sample_shift = 4'd9;
		regs_shadow.trace_value  = 8'd255;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
			0: begin
				send_gap_pct = 0;
				rsp_stall_pct = 0;
				program_regs(8'd2, 4'd9, 8'd255);
			end
			1: begin
				send_gap_pct = 0;
				rsp_stall_pct = 0;
				program_regs(8'd0, 4'd0, 8'd128);
			end
			2: begin
				send_gap_pct = 75;
				rsp_stall_pct = 0;
				program_regs(8'd255, 4'd15, 8'd0);
			end
			3: begin
				send_gap_pct = 0;
				rsp_stall_pct = 75;
				program_regs(8'd5, 4'd4, 8'd255);
			end
			default: begin
				send_gap_pct = 20;
				rsp_stall_pct = 20;
				program_regs(8'd1, 4'd9, 8'd77);
			end
			endcase

			if (ph == 0) begin
				// empty frame, ignored type, full-scale samples both ways, truncation
				queue_read(8'd0, 7'd0);
				req_q.push_back(noise_item(REQ_NONE));
				queue_write(7'd0, 16'sd32767, 16'sd32767);
				queue_write(7'd1, -16'sd32768, -16'sd32768);
				queue_write(7'd2, 16'sd512, -16'sd1025);
				queue_write(7'd3, -16'sd1, -16'sd513);
				queue_write(7'd127, -16'sd32768, 16'sd32767);
				queue_write(7'd64, 16'sd0, -16'sd1);
				req_q.push_back(noise_item(REQ_RENDER));
				queue_read(8'd0, 7'd0);
				queue_read(8'd255, 7'd0);
				queue_read(8'd0, 7'd127);
				queue_read(8'd255, 7'd127);
				queue_read(8'd1, 7'd127);
				queue_read(8'd2, 7'd0);
				req_q.push_back(noise_item(REQ_NONE));
				queue_write(7'd5, sample_value(), sample_value());
			end else begin
				// mostly sweeps of consecutive pairs, one render, some noise
				idx = $urandom_range(SMP_MASK);
				for (int k = 0; k < 12; k++) begin
					if (k == 8)
						req_q.push_back(noise_item(REQ_RENDER));
					else begin
						roll = $urandom_range(99);
						if (roll < 65) begin
							if ($urandom_range(3) == 0)
								idx = $urandom_range(SMP_MASK);
							queue_write(7'(idx), sample_value(), sample_value());
							idx++;
						end else if (roll < 75)
							req_q.push_back(noise_item(REQ_NONE));
						else
							req_q.push_back(noise_item(REQ_READ));
					end
				end
			end
			wait_all_answered();

			// reads aimed mostly at lit pixels of the frame as it now stands
			for (int k = 0; k < 8; k++) begin
				x = $urandom_range(FRAME_WIDTH - 1);
				y0 = $urandom_range(FRAME_HEIGHT - 1);
				if ($urandom_range(3) != 0)
					for (int s = 0; s < FRAME_HEIGHT; s++)
						if (frame_px[((y0 + s) % FRAME_HEIGHT + 1) * ROW_STRIDE + x + 1] != 0) begin
							y0 = (y0 + s) % FRAME_HEIGHT;
							break;
						end
				queue_read(8'(x), 7'(y0));
			end
			wait_all_answered();
			repeat (8) @(posedge clk);
		end

		repeat (20) @(posedge clk);
		if (n_fail == 0)
			$display("blur_scope_frame_renderer regression: pass");
		else
			$display("blur_scope_frame_renderer regression: fail");
		$finish;
	end

	// Watchdog: its limit well covers five renders plus the clearing pass
	initial begin
		#50_000_000;
		$display("blur_scope_frame_renderer regression: fail");
		$finish;
	end

endmodule
